### design/spirv_local_size_patcher_core_defines.svh
// ----------------------------------------------------------------------------
// spirv_local_size_patcher_core_defines
// Assertion macros used by the checker file of the local size patcher.
// ----------------------------------------------------------------------------
`ifndef SPIRV_LOCAL_SIZE_PATCHER_CORE_DEFINES_SVH
`define SPIRV_LOCAL_SIZE_PATCHER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsp: same-cycle check failed");

// next-cycle implication, checked out of reset
`define LSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsp: next-cycle check failed");

`endif

### design/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// Types and constants of the SPIR-V local size patcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

  localparam int WORD_W      = 32;
  localparam int TOTAL_W     = 23;
  localparam int SIZE_W      = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int BATCH_MAX   = 4;

  localparam logic [2:0]  HEADER_WORDS           = 3'd5;
  localparam logic [15:0] OP_EXECUTION_MODE      = 16'd16;
  localparam logic [15:0] OP_DECORATE            = 16'd71;
  localparam logic [15:0] DECORATE_MIN_WC        = 16'd4;
  localparam logic [31:0] EXEC_MODE_LOCAL_SIZE   = 32'd17;
  localparam logic [31:0] DECORATION_BUILTIN     = 32'd11;
  localparam logic [31:0] BUILTIN_WORKGROUP_SIZE = 32'd25;

  // operand positions within an instruction (position saturates at 7)
  localparam logic [2:0] POS_TARGET = 3'd1;
  localparam logic [2:0] POS_MODE   = 3'd2;
  localparam logic [2:0] POS_X      = 3'd3;
  localparam logic [2:0] POS_Y      = 3'd4;
  localparam logic [2:0] POS_Z      = 3'd5;
  localparam logic [2:0] POS_SAT    = 3'd7;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SIZE_X = 2'd0;
  localparam cfg_idx_t CFG_SIZE_Y = 2'd1;
  localparam cfg_idx_t CFG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                          cnt;
    logic                                nodata;
    logic                                last;
    logic [TOTAL_W-1:0]                  total;
    logic [BATCH_MAX-1:0][WORD_W-1:0]    words;
  } batch_t;

endpackage

`default_nettype wire

### design/lsp_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsp_cfg_regs
// Local size registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire lsp_pkg::cfg_idx_t          wr_index,
  input  wire logic [lsp_pkg::SIZE_W-1:0] wr_data,
  output lsp_pkg::cfg_t                   cfg
);

  lsp_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        lsp_pkg::CFG_SIZE_X: cfg_nxt.size_x = wr_data;
        lsp_pkg::CFG_SIZE_Y: cfg_nxt.size_y = wr_data;
        lsp_pkg::CFG_SIZE_Z: cfg_nxt.size_z = wr_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{size_x: 16'd1, size_y: 16'd1, size_z: 16'd1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### design/lsp_decoder.sv
// ----------------------------------------------------------------------------
// lsp_decoder
// Input register and instruction parser; builds the result batch of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_decoder #(
  parameter int MAX_MODULE_WORDS = 1048576
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [lsp_pkg::WORD_W-1:0] in_word,
  input  wire logic                       in_last,
  input  wire lsp_pkg::cfg_t              cfg,
  input  wire logic                       batch_ready,
  output logic                            batch_load,
  output lsp_pkg::batch_t                 batch
);

  localparam int EW = $clog2(MAX_MODULE_WORDS + 1);
  localparam logic [EW:0] EW_MAX = (EW+1)'(MAX_MODULE_WORDS);

  logic                       full_r, full_nxt;
  logic [lsp_pkg::WORD_W-1:0] word_r;
  logic                       last_r;

  logic [2:0]  hdr_r, hdr_nxt;
  logic [15:0] wl_r, wl_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        exec_r, exec_nxt;
  logic [1:0]  hold_r, hold_nxt;
  logic        rew_r, rew_nxt;
  logic        drop_r, drop_nxt;
  logic [EW-1:0] em_r, em_nxt;
  logic [lsp_pkg::WORD_W-1:0] h0_r, h0_nxt, h1_r, h1_nxt;

  logic in_xfer;

  assign in_xfer    = in_valid && in_ready;
  assign batch_load = full_r && batch_ready;
  assign in_ready   = !full_r || batch_ready;

  always_comb begin
    full_nxt = full_r;
    if (in_xfer) begin
      full_nxt = 1'b1;
    end else if (batch_load) begin
      full_nxt = 1'b0;
    end
  end

  always_comb begin
    logic [15:0] wc;
    logic [2:0]  pos;
    logic [2:0]  n;
    logic [EW:0] em_sum;
    hdr_nxt  = hdr_r;
    wl_nxt   = wl_r;
    pos_nxt  = pos_r;
    exec_nxt = exec_r;
    hold_nxt = hold_r;
    rew_nxt  = rew_r;
    drop_nxt = drop_r;
    h0_nxt   = h0_r;
    h1_nxt   = h1_r;
    em_nxt   = em_r;
    wc       = word_r[31:16];
    pos      = (pos_r == lsp_pkg::POS_SAT) ? pos_r : pos_r + 3'd1;
    n        = 3'd0;
    em_sum   = '0;
    batch    = '0;

    if (hdr_r != 3'd0) begin
      batch.words[0] = word_r;
      n              = 3'd1;
      hdr_nxt        = hdr_r - 3'd1;
    end else if (wl_r == 16'd0) begin
      if (wc == 16'd0) begin
        wc = 16'd1;
      end
      exec_nxt = (word_r[15:0] == lsp_pkg::OP_EXECUTION_MODE);
      pos_nxt  = 3'd0;
      wl_nxt   = wc - 16'd1;
      rew_nxt  = 1'b0;
      drop_nxt = 1'b0;
      hold_nxt = 2'd0;
      if (word_r[15:0] == lsp_pkg::OP_DECORATE && wc >= lsp_pkg::DECORATE_MIN_WC) begin
        h0_nxt   = word_r;
        hold_nxt = 2'd1;
      end else begin
        batch.words[0] = word_r;
        n              = 3'd1;
      end
    end else begin
      pos_nxt = pos;
      wl_nxt  = wl_r - 16'd1;
      if (drop_r) begin
        n = 3'd0;
      end else if (hold_r != 2'd0) begin
        if (pos == lsp_pkg::POS_TARGET) begin
          h1_nxt   = word_r;
          hold_nxt = 2'd2;
        end else if (pos == lsp_pkg::POS_MODE) begin
          if (word_r != lsp_pkg::DECORATION_BUILTIN) begin
            batch.words[0] = h0_r;
            batch.words[1] = h1_r;
            batch.words[2] = word_r;
            n              = 3'd3;
            hold_nxt       = 2'd0;
          end else begin
            hold_nxt = 2'd3;
          end
        end else if (word_r == lsp_pkg::BUILTIN_WORKGROUP_SIZE) begin
          hold_nxt = 2'd0;
          drop_nxt = 1'b1;
        end else begin
          batch.words[0] = h0_r;
          batch.words[1] = h1_r;
          batch.words[2] = lsp_pkg::DECORATION_BUILTIN;
          batch.words[3] = word_r;
          n              = 3'd4;
          hold_nxt       = 2'd0;
        end
      end else begin
        batch.words[0] = word_r;
        n              = 3'd1;
        if (exec_r) begin
          if (pos == lsp_pkg::POS_MODE && word_r == lsp_pkg::EXEC_MODE_LOCAL_SIZE) begin
            rew_nxt = 1'b1;
          end else if (rew_r && pos == lsp_pkg::POS_X) begin
            batch.words[0] = 32'(cfg.size_x);
          end else if (rew_r && pos == lsp_pkg::POS_Y) begin
            batch.words[0] = 32'(cfg.size_y);
          end else if (rew_r && pos == lsp_pkg::POS_Z) begin
            batch.words[0] = 32'(cfg.size_z);
          end
        end
      end
    end

    // end of module: flush held words (nothing else is emitted while holding)
    if (last_r && hold_nxt != 2'd0) begin
      batch.words[0] = h0_nxt;
      batch.words[1] = h1_nxt;
      batch.words[2] = lsp_pkg::DECORATION_BUILTIN;
      n              = 3'(hold_nxt);
    end

    em_sum = (EW+1)'(em_r) + (EW+1)'(n);
    if (em_sum > EW_MAX) begin
      em_sum = EW_MAX;
    end
    em_nxt = em_sum[EW-1:0];

    batch.cnt = n;
    if (last_r) begin
      batch.last  = 1'b1;
      batch.total = lsp_pkg::TOTAL_W'(em_sum) << 2;
      if (n == 3'd0) begin
        batch.cnt    = 3'd1;
        batch.nodata = 1'b1;
      end
      hdr_nxt  = lsp_pkg::HEADER_WORDS;
      wl_nxt   = 16'd0;
      pos_nxt  = 3'd0;
      exec_nxt = 1'b0;
      hold_nxt = 2'd0;
      rew_nxt  = 1'b0;
      drop_nxt = 1'b0;
      em_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      word_r <= in_word;
      last_r <= in_last;
    end
    if (batch_load) begin
      h0_r <= h0_nxt;
      h1_r <= h1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      hdr_r  <= lsp_pkg::HEADER_WORDS;
      wl_r   <= '0;
      pos_r  <= '0;
      exec_r <= 1'b0;
      hold_r <= '0;
      rew_r  <= 1'b0;
      drop_r <= 1'b0;
      em_r   <= '0;
    end else begin
      full_r <= full_nxt;
      if (batch_load) begin
        hdr_r  <= hdr_nxt;
        wl_r   <= wl_nxt;
        pos_r  <= pos_nxt;
        exec_r <= exec_nxt;
        hold_r <= hold_nxt;
        rew_r  <= rew_nxt;
        drop_r <= drop_nxt;
        em_r   <= em_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### design/lsp_out_serializer.sv
// ----------------------------------------------------------------------------
// lsp_out_serializer
// Result register holding one batch; hands its words out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lsp_out_serializer (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            load,
  input  wire lsp_pkg::batch_t                 batch,
  output logic                                 load_ready,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lsp_pkg::OUT_TDATA_W-1:0]      out_data,
  output logic                                 out_flag,
  output logic                                 out_end
);

  lsp_pkg::batch_t batch_r;
  logic [1:0]      idx_r, idx_nxt;
  logic [2:0]      cnt_nxt;
  logic            final_word;
  logic            xfer;

  assign out_valid  = batch_r.cnt != 3'd0;
  assign final_word = idx_r == 2'(batch_r.cnt - 3'd1);
  assign xfer       = out_valid && out_ready;
  assign load_ready = !out_valid || (xfer && final_word);

  assign out_end  = batch_r.last && final_word;
  assign out_flag = !(batch_r.nodata);
  assign out_data = {1'b0, (out_end ? batch_r.total : '0), batch_r.words[idx_r]};

  always_comb begin
    idx_nxt = idx_r;
    cnt_nxt = batch_r.cnt;
    if (load) begin
      idx_nxt = 2'd0;
      cnt_nxt = batch.cnt;
    end else if (xfer) begin
      if (final_word) begin
        cnt_nxt = 3'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      batch_r.nodata <= batch.nodata;
      batch_r.last   <= batch.last;
      batch_r.total  <= batch.total;
      batch_r.words  <= batch.words;
    end
    if (!rst_n) begin
      batch_r.cnt <= '0;
      idx_r       <= '0;
    end else begin
      batch_r.cnt <= cnt_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

### design/spirv_local_size_patcher_core.sv
// A SPIR-V module enters one 32-bit word per transfer. Each accepted word
// passes an input register and a single decode step into a result register
// that holds up to four output words; a new word is taken every cycle as long
// as each word yields at most one output word and the output is not stalled.
// A word that releases held OpDecorate words yields up to four, handed out
// one per transfer; the next word waits until the last is taken. LocalSize
// operands are taken from the size registers when the word is decoded.
// ----------------------------------------------------------------------------
// spirv_local_size_patcher_core
// Patches OpExecutionMode LocalSize and drops WorkgroupSize decorations.
// ----------------------------------------------------------------------------
`default_nettype none

module spirv_local_size_patcher_core #(
  parameter int MAX_MODULE_WORDS = 1048576
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] in_word
  input  wire logic        in_tlast,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [31:0] out_word, [54:32] total_bytes
  output logic             out_tuser,  // [0] out_valid
  output logic             out_tlast
);

  lsp_pkg::cfg_t   cfg;
  lsp_pkg::batch_t batch;
  logic            batch_load;
  logic            batch_ready;

  assign cfg_ready = 1'b1;

  lsp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  lsp_decoder #(
    .MAX_MODULE_WORDS (MAX_MODULE_WORDS)
  ) u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_word     (in_tdata),
    .in_last     (in_tlast),
    .cfg         (cfg),
    .batch_ready (batch_ready),
    .batch_load  (batch_load),
    .batch       (batch)
  );

  lsp_out_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (batch_load),
    .batch      (batch),
    .load_ready (batch_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_flag   (out_tuser),
    .out_end    (out_tlast)
  );

endmodule

`default_nettype wire

### design/lsp_checker.sv
// ----------------------------------------------------------------------------
// lsp_checker
// Port-level checks of the local size patcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spirv_local_size_patcher_core_defines.svh"

module lsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  `LSP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `LSP_ASSERT_NOW(a_total_on_end, out_tvalid && !out_tlast, out_tdata[54:32] == 23'd0)
  `LSP_ASSERT_NOW(a_marker_on_end, out_tvalid && !out_tuser, out_tlast && out_tdata[31:0] == 32'd0)
  `LSP_ASSERT_NOW(a_ready_when_idle, !out_tvalid, in_tready)

endmodule

bind spirv_local_size_patcher_core lsp_checker u_lsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
